// File: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// condition must never hold
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// File: hw/rtl/sdt_pkg.sv
package sdt_pkg;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_VBLANK = 2'd2,
      OP_DONE   = 2'd3
   } op_type;

   // register offsets
   localparam logic [7:0] OFS_LIST_BASE = 8'h04;
   localparam logic [7:0] OFS_TRIG_SEL  = 8'h10;
   localparam logic [7:0] OFS_ENABLE    = 8'h14;
   localparam logic [7:0] OFS_BUSY      = 8'h18;
   localparam logic [7:0] OFS_SYSCTL    = 8'h80;
   localparam logic [7:0] OFS_TRIG_CLR  = 8'h88;
   localparam logic [7:0] OFS_AREA      = 8'h8C;
   localparam logic [7:0] OFS_ENDIAN    = 8'hE8;

   localparam logic [31:0] SYSCTL_RESET   = 32'h3A98_0000;
   localparam logic [15:0] AREA_KEY       = 16'h6155;
   localparam int          SYSCTL_TRIG_RST_BIT = 12;
   localparam int          ADDR_LSB       = 5;
   localparam int          ADDR_W         = 29;
   localparam int          BASE_W         = ADDR_W - ADDR_LSB;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  offset;
      logic [31:0] write_data;
   } item_type;

   typedef struct packed {
      logic [31:0]       read_data;
      logic              start_transfer;
      logic [ADDR_W-1:0] list_address;
      logic              done_irq;
   } result_type;

   typedef struct packed {
      logic busy;
      logic enable;
   } status_type;

endpackage

// File: hw/rtl/sdt_core.sv
module sdt_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  sdt_pkg::item_type   item,
   output sdt_pkg::result_type result,
   output sdt_pkg::status_type status
);
   import sdt_pkg::*;

   logic [BASE_W-1:0] list_base_ff, list_base_in;
   logic              trig_sel_ff, trig_sel_in;
   logic              enable_ff, enable_in;
   logic              busy_ff, busy_in;
   logic [31:0]       sysctl_ff, sysctl_in;
   logic [6:0]        area_hi_ff, area_hi_in;
   logic [6:0]        area_lo_ff, area_lo_in;
   logic              endian_ff, endian_in;
   logic              pending_ff, pending_in;

   logic [31:0]       rdata;
   logic              start;
   logic              irq;

   always_comb begin
      list_base_in = list_base_ff;
      trig_sel_in  = trig_sel_ff;
      enable_in    = enable_ff;
      busy_in      = busy_ff;
      sysctl_in    = sysctl_ff;
      area_hi_in   = area_hi_ff;
      area_lo_in   = area_lo_ff;
      endian_in    = endian_ff;
      pending_in   = pending_ff;
      rdata        = '0;
      start        = 1'b0;
      irq          = 1'b0;
      case (item.operation)
         OP_READ: begin
            case (item.offset)
               OFS_LIST_BASE: rdata = {3'b0, list_base_ff, 5'b0};
               OFS_TRIG_SEL:  rdata = {31'b0, trig_sel_ff};
               OFS_ENABLE:    rdata = {31'b0, enable_ff};
               OFS_BUSY:      rdata = {31'b0, busy_ff};
               OFS_SYSCTL:    rdata = sysctl_ff;
               OFS_AREA:      rdata = {17'b0, area_hi_ff, 1'b0, area_lo_ff};
               OFS_ENDIAN:    rdata = {31'b0, endian_ff};
               default:       rdata = '0;
            endcase
         end
         OP_WRITE: begin
            case (item.offset)
               OFS_LIST_BASE: list_base_in = item.write_data[ADDR_W-1:ADDR_LSB];
               OFS_TRIG_SEL:  trig_sel_in = item.write_data[0];
               OFS_ENABLE: begin
                  enable_in = item.write_data[0];
                  if (!item.write_data[0]) begin
                     busy_in = 1'b0;
                  end
               end
               OFS_BUSY: begin
                  if (item.write_data[0] && enable_ff && !busy_ff) begin
                     busy_in = 1'b1;
                     start   = 1'b1;
                  end
               end
               OFS_SYSCTL: sysctl_in = item.write_data;
               OFS_TRIG_CLR: begin
                  if (item.write_data[0]) begin
                     pending_in = 1'b0;
                  end
               end
               OFS_AREA: begin
                  if (item.write_data[31:16] == AREA_KEY) begin
                     area_hi_in = item.write_data[14:8];
                     area_lo_in = item.write_data[6:0];
                  end
               end
               OFS_ENDIAN: endian_in = item.write_data[0];
               default: ;
            endcase
         end
         OP_VBLANK: begin
            if (enable_ff) begin
               if (trig_sel_ff) begin
                  if (!pending_ff) begin
                     busy_in = 1'b1;
                     start   = 1'b1;
                     if (sysctl_ff[SYSCTL_TRIG_RST_BIT]) begin
                        pending_in = 1'b1;
                     end
                  end
               end else begin
                  pending_in = 1'b0;
               end
            end
         end
         OP_DONE: begin
            if (busy_ff) begin
               irq     = enable_ff;
               busy_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_base_ff <= '0;
         trig_sel_ff  <= 1'b0;
         enable_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         sysctl_ff    <= SYSCTL_RESET;
         area_hi_ff   <= 7'h7F;
         area_lo_ff   <= 7'h00;
         endian_ff    <= 1'b1;
         pending_ff   <= 1'b0;
      end else if (fire) begin
         list_base_ff <= list_base_in;
         trig_sel_ff  <= trig_sel_in;
         enable_ff    <= enable_in;
         busy_ff      <= busy_in;
         sysctl_ff    <= sysctl_in;
         area_hi_ff   <= area_hi_in;
         area_lo_ff   <= area_lo_in;
         endian_ff    <= endian_in;
         pending_ff   <= pending_in;
      end
   end

   assign result.read_data      = rdata;
   assign result.start_transfer = start;
   assign result.list_address   = start ? {list_base_ff, 5'b0} : '0;
   assign result.done_irq       = irq;

   assign status.busy   = busy_ff;
   assign status.enable = enable_ff;

endmodule

// File: hw/rtl/sdt_out_stage.sv
module sdt_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sdt_pkg::result_type result,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sdt_pkg::result_type rsp_result
);
   import sdt_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

endmodule

// File: hw/rtl/serial_dma_trigger_regs.sv
// register block of a serial-bus dma controller with its trigger logic. each
// item is a register read, a register write, a vertical-blank tick or a
// transfer-done event, and gives exactly one result item: read data, a start
// pulse with the 32-byte aligned descriptor list address, and the done
// interrupt. an item passes an input register, then the decode and state
// update logic into the result register, which drives rsp_valid; an item
// waits in the input register while the result slot is stalled; one item is
// taken every cycle as long as rsp_ready keeps up; the block state is
// updated as an item moves into the result register, so every item sees the
// effect of the ones before it
module serial_dma_trigger_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_operation,
   input  logic [7:0]                   req_offset,
   input  logic [31:0]                  req_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [31:0]                  rsp_read_data,
   output logic                         rsp_start_transfer,
   output logic [sdt_pkg::ADDR_W-1:0]   rsp_list_address,
   output logic                         rsp_done_irq
);
   import sdt_pkg::*;

   `include "assert_macros.svh"

   // input register
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;

   logic       out_free;
   logic       advance;
   logic       req_fire;
   result_type core_result;
   result_type out_result;
   status_type core_status;

   // item moves to the result register when that slot frees up
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.operation  <= op_type'(req_operation);
         in_item_ff.offset     <= req_offset;
         in_item_ff.write_data <= req_write_data;
      end
   end

   // register decode and trigger state
   sdt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (core_result),
      .status (core_status)
   );

   // result register
   sdt_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (core_result),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (out_result)
   );

   assign rsp_read_data      = out_result.read_data;
   assign rsp_start_transfer = out_result.start_transfer;
   assign rsp_list_address   = out_result.list_address;
   assign rsp_done_irq       = out_result.done_irq;

   // a start leaves the block busy
   `ASSERT_NEXT(a_start_sets_busy, clock, reset,
      advance && core_result.start_transfer, core_status.busy)
   // an interrupt only comes from a busy, enabled block, and never with a start
   `ASSERT_IMPLIES(a_irq_source, clock, reset, advance && core_result.done_irq,
      core_status.busy && core_status.enable && !core_result.start_transfer)
   // address is zero outside a start pulse
   `ASSERT_IMPLIES(a_addr_quiet, clock, reset, rsp_valid && !rsp_start_transfer,
      rsp_list_address == '0)
   // a held item must not be overwritten while the result slot is stalled
   `ASSERT_NEVER(a_no_overrun, clock, reset, in_valid_ff && !out_free && req_ready)

endmodule

// File: tb/serial_dma_trigger_regs_test.sv
`timescale 1ns / 1ps

module serial_dma_trigger_regs_test;
   import sdt_pkg::*;

   localparam int          CLK_PERIOD     = 10;
   localparam int          RESET_CYCLES   = 12;
   localparam int          RANDOM_ITEMS   = 1324;
   localparam int          DIRECTED_ROWS  = 26;
   // longest legal quiet stretch is a sender gap plus a receiver stall, well under this
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          DRAIN_CYCLES   = 10;
   localparam int          REPORT_LIMIT   = 10;

   localparam logic [31:0] LIST_ADDR_MASK = 32'h1FFF_FFE0;
   localparam logic [31:0] AREA_MASK      = 32'h0000_7F7F;
   localparam logic [31:0] AREA_RESET     = 32'h0000_7F00;
   localparam logic [7:0]  OFS_SPARE      = 8'h84;
   localparam logic [7:0]  OFS_UNMAPPED   = 8'hFF;

   // one row of the directed table; want is only used when fixed is set
   typedef struct packed {
      item_type   stim;
      logic       fixed;
      result_type want;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_operation;
   logic [7:0]          req_offset;
   logic [31:0]         req_write_data;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [31:0]         rsp_read_data;
   logic                rsp_start_transfer;
   logic [ADDR_W-1:0]   rsp_list_address;
   logic                rsp_done_irq;

   // shadow copy of the register block state
   logic [31:0]         shadow_base;
   logic                shadow_trig_sel;
   logic                shadow_enable;
   logic                shadow_busy;
   logic [31:0]         shadow_sysctl;
   logic [31:0]         shadow_area;
   logic                shadow_endian;
   logic                shadow_pending;

   result_type          dma_results_due [$];
   dir_row_type         directed_steps [DIRECTED_ROWS];
   logic [7:0]          mapped_offsets [9];
   int                  error_count = 0;
   int                  stall_cycles = 0;
   // when set, neither side inserts idle cycles
   bit                  quiet = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   serial_dma_trigger_regs u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_offset         (req_offset),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_data      (rsp_read_data),
      .rsp_start_transfer (rsp_start_transfer),
      .rsp_list_address   (rsp_list_address),
      .rsp_done_irq       (rsp_done_irq)
   );

   // expected result of one item, advancing the shadow state as the block does
   function automatic result_type predict_dma_regs(input item_type it);
      result_type r;
      r = '0;
      case (it.operation)
         OP_READ: begin
            case (it.offset)
               OFS_LIST_BASE: r.read_data = shadow_base;
               OFS_TRIG_SEL:  r.read_data = 32'(shadow_trig_sel);
               OFS_ENABLE:    r.read_data = 32'(shadow_enable);
               OFS_BUSY:      r.read_data = 32'(shadow_busy);
               OFS_SYSCTL:    r.read_data = shadow_sysctl;
               OFS_AREA:      r.read_data = shadow_area;
               OFS_ENDIAN:    r.read_data = 32'(shadow_endian);
               default:       r.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (it.offset)
               OFS_LIST_BASE: shadow_base = it.write_data & LIST_ADDR_MASK;
               OFS_TRIG_SEL:  shadow_trig_sel = it.write_data[0];
               OFS_ENABLE: begin
                  shadow_enable = it.write_data[0];
                  // disabling also drops busy
                  if (!it.write_data[0]) shadow_busy = 1'b0;
               end
               OFS_BUSY: begin
                  // software start only from an enabled, idle block
                  if (it.write_data[0] && shadow_enable && !shadow_busy) begin
                     shadow_busy = 1'b1;
                     r.start_transfer = 1'b1;
                  end
               end
               OFS_SYSCTL:    shadow_sysctl = it.write_data;
               OFS_TRIG_CLR:  if (it.write_data[0]) shadow_pending = 1'b0;
               OFS_AREA: begin
                  // key in the upper half, otherwise the write is dropped
                  if (it.write_data[31:16] == AREA_KEY)
                     shadow_area = it.write_data & AREA_MASK;
               end
               OFS_ENDIAN:    shadow_endian = it.write_data[0];
               default: ;
            endcase
         end
         OP_VBLANK: begin
            if (shadow_enable) begin
               if (shadow_trig_sel) begin
                  // hardware trigger restarts the list even when busy
                  if (!shadow_pending) begin
                     shadow_busy = 1'b1;
                     r.start_transfer = 1'b1;
                     if (shadow_sysctl[SYSCTL_TRIG_RST_BIT]) shadow_pending = 1'b1;
                  end
               end else begin
                  shadow_pending = 1'b0;
               end
            end
         end
         default: begin
            // transfer done: ignored while idle, no interrupt while disabled
            if (shadow_busy) begin
               r.done_irq  = shadow_enable;
               shadow_busy = 1'b0;
            end
         end
      endcase
      if (r.start_transfer) r.list_address = shadow_base[ADDR_W-1:0];
      return r;
   endfunction

   function automatic dir_row_type mk_row(input op_type op, input logic [7:0] ofs,
                                          input logic [31:0] data, input logic fixed,
                                          input logic [31:0] rd, input logic st,
                                          input logic [ADDR_W-1:0] addr, input logic irq);
      dir_row_type d;
      d.stim.operation       = op;
      d.stim.offset          = ofs;
      d.stim.write_data      = data;
      d.fixed                = fixed;
      d.want.read_data       = rd;
      d.want.start_transfer  = st;
      d.want.list_address    = addr;
      d.want.done_irq        = irq;
      return d;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // random access, biased so that starts, triggers and completions happen often
   function automatic item_type random_access();
      item_type it;
      int       roll;
      roll          = $urandom_range(0, 99);
      it.write_data = $urandom;
      it.offset     = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                  : mapped_offsets[$urandom_range(0, 8)];
      if (roll < 25)      it.operation = OP_READ;
      else if (roll < 60) it.operation = OP_WRITE;
      else if (roll < 82) it.operation = OP_VBLANK;
      else                it.operation = OP_DONE;
      if (it.operation == OP_WRITE) begin
         case (it.offset)
            OFS_ENABLE:   it.write_data[0] = ($urandom_range(0, 9) < 8);
            OFS_BUSY:     it.write_data[0] = ($urandom_range(0, 9) < 9);
            OFS_TRIG_SEL: it.write_data[0] = ($urandom_range(0, 9) < 6);
            OFS_TRIG_CLR: it.write_data[0] = ($urandom_range(0, 9) < 7);
            OFS_AREA:     if ($urandom_range(0, 1)) it.write_data[31:16] = AREA_KEY;
            default: ;
         endcase
      end
      return it;
   endfunction

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t: %s", $time, what);
   endtask

   // append one expectation at the tail of the queue
   task automatic queue_expected(input result_type r);
      dma_results_due = {dma_results_due, r};
   endtask

   // present one item at the falling edge and hold it until accepted
   task automatic send_item(input item_type it, input logic fixed, input result_type want);
      int         gap;
      result_type predicted;
      @(negedge clock);
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= it.operation;
      req_offset     <= it.offset;
      req_write_data <= it.write_data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge; shadow state always advances
      predicted = predict_dma_regs(it);
      queue_expected(fixed ? want : predicted);
   endtask

   // result side: ready with random stalls
   initial begin : result_sink
      int run;
      int hold;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         run = $urandom_range(1, 20);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         hold = idle_cycles();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_read_data, rsp_start_transfer, rsp_list_address, rsp_done_irq};
         if (dma_results_due.size() == 0) begin
            flag_error($sformatf("unexpected result rd %h start %b addr %h irq %b",
                                 got.read_data, got.start_transfer, got.list_address,
                                 got.done_irq));
         end else begin
            want = dma_results_due.pop_front();
            if (got.read_data != want.read_data ||
                got.start_transfer != want.start_transfer ||
                got.list_address != want.list_address ||
                got.done_irq != want.done_irq)
               flag_error($sformatf(
                  "mismatch exp/act: rd %h/%h start %b/%b addr %h/%h irq %b/%b",
                  want.read_data, got.read_data, want.start_transfer, got.start_transfer,
                  want.list_address, got.list_address, want.done_irq, got.done_irq));
         end
      end
   end

   // watchdog: too long without any handshake on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      result_type none;
      none           = '0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = '0;
      req_offset     = '0;
      req_write_data = '0;

      mapped_offsets = '{OFS_LIST_BASE, OFS_TRIG_SEL, OFS_ENABLE, OFS_BUSY, OFS_SYSCTL,
                         OFS_SPARE, OFS_TRIG_CLR, OFS_AREA, OFS_ENDIAN};

      // directed table: expected values typed in where they are obvious
      directed_steps = '{
         // reset values
         mk_row(OP_READ,   OFS_LIST_BASE, 32'h0,         1, 32'h0,         0, '0, 0),
         mk_row(OP_READ,   OFS_SYSCTL,    32'h0,         1, SYSCTL_RESET,  0, '0, 0),
         mk_row(OP_READ,   OFS_AREA,      32'h0,         1, AREA_RESET,    0, '0, 0),
         mk_row(OP_READ,   OFS_ENDIAN,    32'h0,         1, 32'h1,         0, '0, 0),
         // unmapped write, tick while disabled, done while idle, start while disabled
         mk_row(OP_WRITE,  OFS_UNMAPPED,  32'hFFFF_FFFF, 1, 32'h0,         0, '0, 0),
         mk_row(OP_VBLANK, OFS_UNMAPPED,  32'hFFFF_FFFF, 1, 32'h0,         0, '0, 0),
         mk_row(OP_DONE,   OFS_UNMAPPED,  32'hFFFF_FFFF, 1, 32'h0,         0, '0, 0),
         mk_row(OP_WRITE,  OFS_BUSY,      32'hFFFF_FFFF, 1, 32'h0,         0, '0, 0),
         // list address masked to 32-byte alignment
         mk_row(OP_WRITE,  OFS_LIST_BASE, 32'hFFFF_FFFF, 1, 32'h0,         0, '0, 0),
         mk_row(OP_READ,   OFS_LIST_BASE, 32'h0,         1, 32'h1FFF_FFE0, 0, '0, 0),
         // software start, then completion with interrupt
         mk_row(OP_WRITE,  OFS_ENABLE,    32'h1,         1, 32'h0,         0, '0, 0),
         mk_row(OP_WRITE,  OFS_BUSY,      32'h1,         1, 32'h0,         1,
                29'h1FFF_FFE0, 0),
         mk_row(OP_DONE,   OFS_LIST_BASE, 32'h0,         1, 32'h0,         0, '0, 1),
         // protected area: wrong key dropped, right key masked
         mk_row(OP_WRITE,  OFS_AREA,      32'hFFFF_FFFF, 0, '0, 0, '0, 0),
         mk_row(OP_WRITE,  OFS_AREA,      32'h6155_FFFF, 0, '0, 0, '0, 0),
         mk_row(OP_READ,   OFS_AREA,      32'h0,         1, 32'h0000_7F7F, 0, '0, 0),
         // hardware trigger with pending latch, blocked, cleared, retriggered
         mk_row(OP_WRITE,  OFS_TRIG_SEL,  32'h1,         0, '0, 0, '0, 0),
         mk_row(OP_WRITE,  OFS_SYSCTL,    32'h0000_1000, 0, '0, 0, '0, 0),
         mk_row(OP_VBLANK, OFS_LIST_BASE, 32'h0,         1, 32'h0,         1,
                29'h1FFF_FFE0, 0),
         mk_row(OP_VBLANK, OFS_LIST_BASE, 32'h0,         0, '0, 0, '0, 0),
         mk_row(OP_WRITE,  OFS_TRIG_CLR,  32'h1,         0, '0, 0, '0, 0),
         mk_row(OP_VBLANK, OFS_LIST_BASE, 32'h0,         0, '0, 0, '0, 0),
         // software select clears the latch at the next tick
         mk_row(OP_WRITE,  OFS_TRIG_SEL,  32'h0,         0, '0, 0, '0, 0),
         mk_row(OP_VBLANK, OFS_LIST_BASE, 32'h0,         0, '0, 0, '0, 0),
         mk_row(OP_WRITE,  OFS_ENDIAN,    32'h0,         0, '0, 0, '0, 0),
         mk_row(OP_READ,   OFS_ENDIAN,    32'h0,         0, '0, 0, '0, 0)
      };

      // shadow state at reset
      shadow_base     = '0;
      shadow_trig_sel = 1'b0;
      shadow_enable   = 1'b0;
      shadow_busy     = 1'b0;
      shadow_sysctl   = SYSCTL_RESET;
      shadow_area     = AREA_RESET;
      shadow_endian   = 1'b1;
      shadow_pending  = 1'b0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         send_item(directed_steps[i].stim, directed_steps[i].fixed, directed_steps[i].want);

      // random items in blocks, some of them without any idling
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 0) quiet = ($urandom_range(0, 2) == 0);
         send_item(random_access(), 1'b0, none);
      end
      quiet = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;

      // drain outstanding results, then keep watching for stray ones
      while (dma_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
